// File: hdl/sldf_pkg.sv
// ----------------------------------------------------------------------------
// sldf_pkg: shared types and constants of the frame deframer
// Payload structs of the two channels, register indexes, function codes and
// the saturating counter step.
// ----------------------------------------------------------------------------
package sldf_pkg;

  localparam int unsigned MAX_BODY_DEF  = 1024;
  localparam int unsigned BUF_DEPTH_DEF = 2048;

  // header: two sync bytes, type, four length bytes; tail: checksum, two sync
  localparam int unsigned HDR_LEN  = 7;
  localparam int unsigned TAIL_LEN = 3;

  localparam logic [7:0] SYNC_RESET = 8'hA5;
  localparam logic [7:0] TYPE_RESET = 8'h01;

  // configuration register indexes
  localparam logic REG_SYNC_BYTE   = 1'b0;
  localparam logic REG_ACCEPT_TYPE = 1'b1;

  // input function codes
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
    logic [9:0] read_index;
  } in_t;

  typedef struct packed {
    logic        new_frame;
    logic [7:0]  frame_type;
    logic [10:0] body_length;
    logic [31:0] frame_count;
    logic [31:0] error_count;
    logic [31:0] unknown_count;
    logic [7:0]  read_data;
    logic        read_valid;
  } out_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

// File: hdl/sldf_stream_if.sv
// ----------------------------------------------------------------------------
// sldf_in_if / sldf_out_if: valid/ready channels of the frame deframer
// A word moves at a rising edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface sldf_in_if;
  import sldf_pkg::*;
  logic valid;
  logic ready;
  in_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface sldf_out_if;
  import sldf_pkg::*;
  logic valid;
  logic ready;
  out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/sldf_ram.sv
// ----------------------------------------------------------------------------
// sldf_ram: simple dual-port byte memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module sldf_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/sync_length_xor_frame_deframer.sv
// ----------------------------------------------------------------------------
// sync_length_xor_frame_deframer: sync/length framed byte stream receiver
// Pulls frames of sync, sync, type, 32-bit length, body, XOR checksum, sync,
// sync out of a byte stream and keeps the body of the last accepted frame.
// ----------------------------------------------------------------------------
// Usage:
//   in_if   : one word per request. func = push carries rx_byte into the
//             receive ring; func = read returns body byte read_index.
//   out_if  : exactly one result word per request, in request order.
//   cfg_*   : write sync_byte (index 0) or accept_type (index 1) while idle.
// Timing:
//   A read passes through ST_RD and ST_DONE into the output register. A push
//   runs a scan of the receive ring through one byte-read port, one byte
//   visited at a time: sync search, header, body checksum, tail and, for
//   accepted frames, the copy into the body store. A failed frame drops
//   one byte and rescans from the front of the ring. One request is in
//   flight at a time; in_if.ready is high only when idle.
// Reset:
//   Ring empty, counters and stored frame cleared, registers at defaults.
//   Memory contents are not cleared; nothing unwritten is ever read.
// Stall:
//   The result sits in an output register; a new request is taken while it
//   waits, and a finished scan holds in place until the register frees.
// ----------------------------------------------------------------------------
module sync_length_xor_frame_deframer import sldf_pkg::*; #(
  parameter int unsigned MAX_BODY  = MAX_BODY_DEF,
  parameter int unsigned BUF_DEPTH = BUF_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [7:0]       cfg_data_i,
  sldf_in_if.sink          in_if,
  sldf_out_if.source       out_if
);

  localparam int unsigned HEAD_W = $clog2(BUF_DEPTH);
  localparam int unsigned FILL_W = $clog2(BUF_DEPTH + 1);
  localparam int unsigned LEN_W  = $clog2(MAX_BODY + 1);
  localparam int unsigned BS_W   = (MAX_BODY > 1) ? $clog2(MAX_BODY) : 1;
  localparam int unsigned POS_W  = ((FILL_W > LEN_W + 4) ? FILL_W : LEN_W + 4) + 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_SYNC, ST_HDR, ST_BODY, ST_TAIL, ST_COPY, ST_DONE
  } state_e;

  typedef struct packed {
    logic [HEAD_W-1:0] head;
    logic [FILL_W-1:0] fill;
  } ptr_t;

  state_e            state_q;
  logic [HEAD_W-1:0] head_q;
  logic [FILL_W-1:0] fill_q;
  logic [POS_W-1:0]  pos_q;
  logic              ph_q;
  logic              prev_q;
  logic              got_q;
  logic              is_read_q;
  logic              rvalid_q;
  logic [9:0]        idx_q;
  logic [7:0]        type_q;
  logic [31:0]       blen_q;
  logic [LEN_W-1:0]  len_q;
  logic [7:0]        xor_q;
  logic              ok_q;
  logic [7:0]        sync_q;
  logic [7:0]        accept_q;
  logic [7:0]        st_type_q;
  logic [LEN_W-1:0]  st_len_q;
  logic              have_q;
  logic [31:0]       frames_q;
  logic [31:0]       errors_q;
  logic [31:0]       unknown_q;
  logic              out_valid_q;
  out_t              out_q;

  logic              in_fire;
  logic              rx_we;
  logic [HEAD_W-1:0] rx_waddr;
  logic [HEAD_W-1:0] rx_raddr;
  logic [7:0]        rx_rdata;
  logic              bs_we;
  logic [BS_W-1:0]   bs_waddr;
  logic [7:0]        bs_rdata;
  logic [31:0]       blen_n;
  logic [LEN_W-1:0]  len_n;
  logic [POS_W-1:0]  pos_fill;
  logic [POS_W-1:0]  body_end;
  logic [POS_W-1:0]  total;
  logic              cur_sync;
  logic              ok_n;
  logic              out_free;

  // wrap a ring offset onto the head; offsets stay below the ring depth
  function automatic logic [HEAD_W-1:0] wrap(input logic [HEAD_W-1:0] h,
                                             input logic [POS_W-1:0]  off);
    logic [HEAD_W:0] sum;
    sum = {1'b0, h} + (HEAD_W+1)'(off);
    if (sum >= (HEAD_W+1)'(BUF_DEPTH)) begin
      sum = sum - (HEAD_W+1)'(BUF_DEPTH);
    end
    return sum[HEAD_W-1:0];
  endfunction

  // drop n bytes from the front; dropping everything resets the head
  function automatic ptr_t drop(input logic [HEAD_W-1:0] h,
                                input logic [FILL_W-1:0] f,
                                input logic [POS_W-1:0]  n);
    ptr_t r;
    if (n >= POS_W'(f)) begin
      r.head = '0;
      r.fill = '0;
    end else begin
      r.head = wrap(h, n);
      r.fill = f - FILL_W'(n);
    end
    return r;
  endfunction

  assign in_fire      = in_if.valid && in_if.ready;
  assign in_if.ready  = (state_q == ST_IDLE);
  assign out_if.valid = out_valid_q;
  assign out_if.payload = out_q;
  assign out_free     = !out_valid_q || out_if.ready;

  // append: a full ring is emptied first, then the byte lands at the front
  assign rx_we    = in_fire && (in_if.payload.func == FUNC_PUSH);
  assign rx_waddr = (fill_q >= FILL_W'(BUF_DEPTH)) ? '0 : wrap(head_q, POS_W'(fill_q));
  assign rx_raddr = wrap(head_q, pos_q);

  assign bs_we    = (state_q == ST_COPY) && ph_q;
  assign bs_waddr = BS_W'(pos_q - POS_W'(HDR_LEN));

  assign blen_n   = {blen_q[23:0], rx_rdata};
  assign len_n    = LEN_W'(blen_n);
  assign pos_fill = POS_W'(fill_q);
  assign body_end = POS_W'(len_q) + POS_W'(HDR_LEN);
  assign total    = POS_W'(len_q) + POS_W'(HDR_LEN + TAIL_LEN);
  assign cur_sync = (rx_rdata == sync_q);
  assign ok_n     = ok_q && ((pos_q == body_end) ? (rx_rdata == xor_q) : cur_sync);

  sldf_ram #(.DEPTH(BUF_DEPTH), .AW(HEAD_W)) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_waddr),
    .wdata_i (in_if.payload.rx_byte),
    .raddr_i (rx_raddr),
    .rdata_o (rx_rdata)
  );

  sldf_ram #(.DEPTH(MAX_BODY), .AW(BS_W)) u_body_ram (
    .clk_i   (clk_i),
    .we_i    (bs_we),
    .waddr_i (bs_waddr),
    .wdata_i (rx_rdata),
    .raddr_i (BS_W'(idx_q)),
    .rdata_o (bs_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    ptr_t d;
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      fill_q      <= '0;
      pos_q       <= '0;
      ph_q        <= 1'b0;
      prev_q      <= 1'b0;
      got_q       <= 1'b0;
      is_read_q   <= 1'b0;
      rvalid_q    <= 1'b0;
      idx_q       <= '0;
      type_q      <= '0;
      blen_q      <= '0;
      len_q       <= '0;
      xor_q       <= '0;
      ok_q        <= 1'b0;
      sync_q      <= SYNC_RESET;
      accept_q    <= TYPE_RESET;
      st_type_q   <= '0;
      st_len_q    <= '0;
      have_q      <= 1'b0;
      frames_q    <= '0;
      errors_q    <= '0;
      unknown_q   <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_SYNC_BYTE:   sync_q   <= cfg_data_i;
          REG_ACCEPT_TYPE: accept_q <= cfg_data_i;
          default: ;
        endcase
      end
      // drain the output register; a finishing scan refills it below
      if (out_valid_q && out_if.ready && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            got_q     <= 1'b0;
            rvalid_q  <= 1'b0;
            idx_q     <= in_if.payload.read_index;
            is_read_q <= (in_if.payload.func == FUNC_READ);
            if (in_if.payload.func == FUNC_READ) begin
              state_q <= ST_RD;
            end else begin
              if (fill_q >= FILL_W'(BUF_DEPTH)) begin
                head_q <= '0;
                fill_q <= FILL_W'(1);
              end else begin
                fill_q <= fill_q + FILL_W'(1);
              end
              pos_q   <= '0;
              prev_q  <= 1'b0;
              ph_q    <= 1'b0;
              state_q <= ST_SYNC;
            end
          end
        end

        ST_RD: begin
          rvalid_q <= have_q && (32'(idx_q) < 32'(st_len_q)) && (32'(idx_q) < MAX_BODY);
          state_q  <= ST_DONE;
        end

        ST_SYNC: begin
          if (!ph_q) begin
            if (pos_q >= pos_fill) begin
              // no sync pair: keep a trailing sync byte as a half header
              if ((fill_q != '0) && prev_q) begin
                d = drop(head_q, fill_q, pos_fill - POS_W'(1));
              end else begin
                d = drop(head_q, fill_q, pos_fill);
              end
              head_q  <= d.head;
              fill_q  <= d.fill;
              state_q <= ST_DONE;
            end else begin
              ph_q <= 1'b1;
            end
          end else begin
            ph_q <= 1'b0;
            if (cur_sync && prev_q) begin
              d = drop(head_q, fill_q, pos_q - POS_W'(1));
              head_q <= d.head;
              fill_q <= d.fill;
              if (d.fill < FILL_W'(HDR_LEN)) begin
                state_q <= ST_DONE;
              end else begin
                pos_q   <= POS_W'(2);
                state_q <= ST_HDR;
              end
            end else begin
              prev_q <= cur_sync;
              pos_q  <= pos_q + POS_W'(1);
            end
          end
        end

        ST_HDR: begin
          if (!ph_q) begin
            ph_q <= 1'b1;
          end else begin
            ph_q <= 1'b0;
            if (pos_q == POS_W'(2)) begin
              type_q <= rx_rdata;
            end else begin
              blen_q <= blen_n;
            end
            if (pos_q == POS_W'(HDR_LEN - 1)) begin
              if (blen_n > 32'(MAX_BODY)) begin
                // over-long length: count, drop one byte, rescan
                errors_q <= sat_inc(errors_q);
                d = drop(head_q, fill_q, POS_W'(1));
                head_q  <= d.head;
                fill_q  <= d.fill;
                pos_q   <= '0;
                prev_q  <= 1'b0;
                state_q <= ST_SYNC;
              end else if (pos_fill < POS_W'(len_n) + POS_W'(HDR_LEN + TAIL_LEN)) begin
                state_q <= ST_DONE;
              end else begin
                len_q   <= len_n;
                pos_q   <= POS_W'(HDR_LEN);
                xor_q   <= '0;
                ok_q    <= 1'b1;
                state_q <= ST_BODY;
              end
            end else begin
              pos_q <= pos_q + POS_W'(1);
            end
          end
        end

        ST_BODY: begin
          if (!ph_q) begin
            if (pos_q == body_end) begin
              state_q <= ST_TAIL;
            end else begin
              ph_q <= 1'b1;
            end
          end else begin
            ph_q  <= 1'b0;
            xor_q <= xor_q ^ rx_rdata;
            pos_q <= pos_q + POS_W'(1);
          end
        end

        ST_TAIL: begin
          if (!ph_q) begin
            ph_q <= 1'b1;
          end else begin
            ph_q <= 1'b0;
            ok_q <= ok_n;
            if (pos_q == total - POS_W'(1)) begin
              if (!ok_n) begin
                errors_q <= sat_inc(errors_q);
                d = drop(head_q, fill_q, POS_W'(1));
                head_q  <= d.head;
                fill_q  <= d.fill;
                pos_q   <= '0;
                prev_q  <= 1'b0;
                state_q <= ST_SYNC;
              end else if (type_q == accept_q) begin
                pos_q   <= POS_W'(HDR_LEN);
                state_q <= ST_COPY;
              end else begin
                unknown_q <= sat_inc(unknown_q);
                d = drop(head_q, fill_q, total);
                head_q  <= d.head;
                fill_q  <= d.fill;
                pos_q   <= '0;
                prev_q  <= 1'b0;
                state_q <= ST_SYNC;
              end
            end else begin
              pos_q <= pos_q + POS_W'(1);
            end
          end
        end

        ST_COPY: begin
          if (!ph_q) begin
            if (pos_q == body_end) begin
              st_type_q <= type_q;
              st_len_q  <= len_q;
              have_q    <= 1'b1;
              frames_q  <= sat_inc(frames_q);
              got_q     <= 1'b1;
              d = drop(head_q, fill_q, total);
              head_q  <= d.head;
              fill_q  <= d.fill;
              pos_q   <= '0;
              prev_q  <= 1'b0;
              state_q <= ST_SYNC;
            end else begin
              ph_q <= 1'b1;
            end
          end else begin
            ph_q  <= 1'b0;
            pos_q <= pos_q + POS_W'(1);
          end
        end

        ST_DONE: begin
          // hold the result until the output register frees
          if (out_free) begin
            out_q.new_frame     <= got_q;
            out_q.frame_type    <= st_type_q;
            out_q.body_length   <= 11'(st_len_q);
            out_q.frame_count   <= frames_q;
            out_q.error_count   <= errors_q;
            out_q.unknown_count <= unknown_q;
            out_q.read_data     <= (is_read_q && rvalid_q) ? bs_rdata : 8'h00;
            out_q.read_valid    <= is_read_q && rvalid_q;
            out_valid_q         <= 1'b1;
            state_q             <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(BUF_DEPTH))
    else $error("ring fill exceeds depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != '0) |-> (32'(head_q) < BUF_DEPTH))
    else $error("ring head out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != ST_IDLE))
    else $error("accepted word did not start work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COPY) |-> ((type_q == accept_q) && (32'(len_q) <= MAX_BODY)))
    else $error("copy of a frame that was not accepted");

endmodule

// File: sim/sldf_scoreboard.sv
// ----------------------------------------------------------------------------
// sldf_scoreboard: result checker of the frame deframer
// Watches the request and result channels and the register port, runs its
// own model of the frame scan on every accepted push, predicts a result for
// every accepted request and compares each result word with the oldest predicted one.
// ----------------------------------------------------------------------------
module sldf_scoreboard import sldf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  sldf_in_if          req_mon,
  sldf_out_if         res_mon,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o
);

  logic [7:0]  rx_ring[$];
  logic [7:0]  body_mem [MAX_BODY_DEF];
  logic [7:0]  sync_val, accept_val, last_type;
  logic [10:0] last_len;
  logic        have_body;
  logic [31:0] frames, errors, unknowns;
  out_t        expected_q[$];

  function automatic bit scan_ring();
    int unsigned s, blen, total;
    logic [7:0]  chk;
    bit          got;
    got = 0;
    forever begin
      s = 0;
      while (s + 1 < rx_ring.size() && !(rx_ring[s] == sync_val && rx_ring[s+1] == sync_val))
        s++;
      if (s + 1 >= rx_ring.size()) begin
        // keep a trailing sync byte as a possible half header
        if (rx_ring.size() > 0 && rx_ring[rx_ring.size()-1] == sync_val)
          rx_ring = '{sync_val};
        else
          rx_ring.delete();
        return got;
      end
      repeat (s) void'(rx_ring.pop_front());
      if (rx_ring.size() < HDR_LEN) return got;
      blen = {rx_ring[3], rx_ring[4], rx_ring[5], rx_ring[6]};
      if (blen > MAX_BODY_DEF) begin
        errors = sat_inc(errors);
        void'(rx_ring.pop_front());
        continue;
      end
      total = HDR_LEN + blen + TAIL_LEN;
      if (rx_ring.size() < total) return got;
      chk = '0;
      for (int unsigned i = 0; i < blen; i++) chk ^= rx_ring[HDR_LEN + i];
      if (rx_ring[total-2] != sync_val || rx_ring[total-1] != sync_val ||
          rx_ring[total-3] != chk) begin
        errors = sat_inc(errors);
        void'(rx_ring.pop_front());
        continue;
      end
      if (rx_ring[2] == accept_val) begin
        for (int unsigned i = 0; i < blen; i++) body_mem[i] = rx_ring[HDR_LEN + i];
        last_type = rx_ring[2];
        last_len  = blen[10:0];
        have_body = 1'b1;
        frames    = sat_inc(frames);
        got       = 1;
      end else begin
        unknowns = sat_inc(unknowns);
      end
      repeat (total) void'(rx_ring.pop_front());
    end
  endfunction

  function automatic out_t predict_result(in_t req);
    out_t r;
    r = '0;
    if (req.func == FUNC_PUSH) begin
      if (rx_ring.size() >= BUF_DEPTH_DEF) rx_ring.delete();
      rx_ring.push_back(req.rx_byte);
      r.new_frame = scan_ring();
    end else if (have_body && req.read_index < last_len) begin
      r.read_valid = 1'b1;
      r.read_data  = body_mem[req.read_index];
    end
    r.frame_type    = last_type;
    r.body_length   = last_len;
    r.frame_count   = frames;
    r.error_count   = errors;
    r.unknown_count = unknowns;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR %0t: %s got 0x%0h, want 0x%0h", $realtime, what, got, want);
    fail_cnt_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t got, want;
    if (!rst_ni) begin
      rx_ring.delete();
      expected_q.delete();
      sync_val   = SYNC_RESET;
      accept_val = TYPE_RESET;
      last_type  = '0;
      last_len   = '0;
      have_body  = 1'b0;
      frames     = '0;
      errors     = '0;
      unknowns   = '0;
      fail_cnt_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_SYNC_BYTE) sync_val = cfg_data_i;
        else accept_val = cfg_data_i;
      end
      if (req_mon.valid && req_mon.ready)
        expected_q.push_back(predict_result(req_mon.payload));
      if (res_mon.valid && res_mon.ready) begin
        got = res_mon.payload;
        if (expected_q.size() == 0) begin
          $display("ERROR %0t: result word with nothing expected", $realtime);
          fail_cnt_o++;
        end else begin
          want = expected_q.pop_front();
          if (got.new_frame != want.new_frame)
            report_mismatch("new_frame", got.new_frame, want.new_frame);
          if (got.frame_type != want.frame_type)
            report_mismatch("frame_type", got.frame_type, want.frame_type);
          if (got.body_length != want.body_length)
            report_mismatch("body_length", got.body_length, want.body_length);
          if (got.frame_count != want.frame_count)
            report_mismatch("frame_count", got.frame_count, want.frame_count);
          if (got.error_count != want.error_count)
            report_mismatch("error_count", got.error_count, want.error_count);
          if (got.unknown_count != want.unknown_count)
            report_mismatch("unknown_count", got.unknown_count, want.unknown_count);
          if (got.read_data != want.read_data)
            report_mismatch("read_data", got.read_data, want.read_data);
          if (got.read_valid != want.read_valid)
            report_mismatch("read_valid", got.read_valid, want.read_valid);
        end
      end
    end
    pending_o = expected_q.size();
  end

endmodule

// File: sim/sync_length_xor_frame_deframer_tb.sv
// ----------------------------------------------------------------------------
// sync_length_xor_frame_deframer_tb: top of the deframer testbench
// Feeds directed and random byte streams (clean frames, corrupted frames,
// noise) and body reads through the block under several register settings
// and idling patterns; the scoreboard checks every result word.
// ----------------------------------------------------------------------------
module sync_length_xor_frame_deframer_tb;
  import sldf_pkg::*;

  // ways to spoil a frame on purpose
  typedef enum int {CLEAN, BAD_CSUM, BAD_TAIL, TOO_LONG} flaw_e;

  localparam int unsigned WATCHDOG_LIMIT = 40000;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned LONG_BODY      = 200;
  localparam int unsigned PHASE_WORDS    = 70;

  logic        clk, rst_n;
  logic        cfg_we, cfg_idx;
  logic [7:0]  cfg_data;
  int unsigned fail_cnt, pending;

  // idling percentages of the current phase
  int unsigned send_idle_pct, recv_stall_pct;
  logic        hold_req;
  logic [7:0]  cur_sync, cur_type;
  int unsigned word_cnt;
  bit          stim_done;

  sldf_in_if  req_ch ();
  sldf_out_if res_ch ();

  sync_length_xor_frame_deframer dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (req_ch),
    .out_if     (res_ch)
  );

  sldf_scoreboard scoreboard (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_mon    (req_ch),
    .res_mon    (res_ch),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stalls per phase, plus one long hold-off so the
  // output register fills and the block has to stall its request side.
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Abort when no word moves on either channel for too long.
  always @(posedge clk) begin
    int unsigned quiet;
    if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
      quiet = 0;
    else if (++quiet >= WATCHDOG_LIMIT) begin
      $display("sync_length_xor_frame_deframer: mismatch");
      $finish;
    end
  end

  // Offer one request word; idle first as the phase asks, hold valid until taken.
  task automatic send_word(in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.payload <= w;
    do @(posedge clk); while (!req_ch.ready);
    word_cnt++;
  endtask

  task automatic push_byte(logic [7:0] b);
    send_word('{func: FUNC_PUSH, rx_byte: b, read_index: 10'($urandom)});
  endtask

  task automatic read_body(logic [9:0] idx);
    send_word('{func: FUNC_READ, rx_byte: 8'($urandom), read_index: idx});
  endtask

  // Build and push one frame; the flaw spoils checksum, tail or length.
  task automatic send_frame(logic [7:0] ftype, int unsigned len, flaw_e flaw);
    logic [31:0] len_word;
    logic [7:0]  chk, b;
    len_word = len;
    if (flaw == TOO_LONG) len_word = MAX_BODY_DEF + 1 + $urandom_range(1, 32'hFFFF_FBFE) - 1;
    if (flaw == TOO_LONG && $urandom_range(1)) len_word = $urandom | 32'h8000_0000;
    chk = '0;
    push_byte(cur_sync);
    push_byte(cur_sync);
    push_byte(ftype);
    for (int i = 3; i >= 0; i--) push_byte(len_word[8*i +: 8]);
    for (int unsigned i = 0; i < len; i++) begin
      b = $urandom;
      chk ^= b;
      push_byte(b);
    end
    if (flaw == BAD_CSUM) chk ^= 8'(1 << $urandom_range(7));
    push_byte(chk);
    push_byte(cur_sync);
    push_byte(flaw == BAD_TAIL ? cur_sync ^ 8'(1 << $urandom_range(7)) : cur_sync);
  endtask

  // Drain, let the block settle, then write one register.
  task automatic write_reg(logic idx, logic [7:0] val);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (8) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    if (idx == REG_SYNC_BYTE) cur_sync = val;
    else cur_type = val;
  endtask

  // One random slice of traffic: mostly frames, some noise and reads.
  task automatic random_traffic(int unsigned words);
    int unsigned stop_at, pick;
    logic [7:0]  ftype;
    stop_at = word_cnt + words;
    while (word_cnt < stop_at) begin
      pick  = $urandom_range(99);
      ftype = $urandom_range(2) != 0 ? cur_type : 8'($urandom);
      if (pick < 45)      send_frame(ftype, $urandom_range(12), CLEAN);
      else if (pick < 52) send_frame(ftype, $urandom_range(8), BAD_CSUM);
      else if (pick < 59) send_frame(ftype, $urandom_range(8), BAD_TAIL);
      else if (pick < 64) send_frame(ftype, $urandom_range(4), TOO_LONG);
      else if (pick < 76) push_byte($urandom_range(3) == 0 ? cur_sync : 8'($urandom));
      else                read_body($urandom_range(3) == 0 ? 10'($urandom) :
                                    10'($urandom_range(15)));
    end
  endtask

  initial begin
    req_ch.valid   <= 1'b0;
    req_ch.payload <= '0;
    cfg_we         <= 1'b0;
    cfg_idx        <= REG_SYNC_BYTE;
    cfg_data       <= '0;
    hold_req       <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cur_sync       = SYNC_RESET;
    cur_type       = TYPE_RESET;
    word_cnt       = 0;
    rst_n          = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reads before any frame, empty body, one wrong type,
    // each flaw, a lone sync byte, and one long frame.
    read_body(10'd0);
    read_body(10'h3FF);
    send_frame(cur_type, 0, CLEAN);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(cur_sync);
    send_frame(cur_type, 2, CLEAN);
    read_body(10'd1);
    read_body(10'd2);
    send_frame(8'h7E, 1, CLEAN);
    send_frame(cur_type, 1, BAD_CSUM);
    send_frame(cur_type, 1, BAD_TAIL);
    send_frame(cur_type, 0, TOO_LONG);
    send_frame(cur_type, LONG_BODY, CLEAN);
    read_body(10'h3FF);
    read_body(10'(LONG_BODY - 1));

    // Register extremes: sync and accepted type at 0x00 and 0xFF.
    write_reg(REG_SYNC_BYTE, 8'h00);
    write_reg(REG_ACCEPT_TYPE, 8'hFF);
    send_frame(8'hFF, 3, CLEAN);
    send_frame(8'h00, 2, CLEAN);
    write_reg(REG_SYNC_BYTE, 8'hFF);
    write_reg(REG_ACCEPT_TYPE, 8'h00);
    send_frame(8'h00, 5, CLEAN);
    read_body(10'd4);

    // Random phases: no idling, idle sender, stalling receiver, both.
    for (int phase = 0; phase < 4; phase++) begin
      write_reg(REG_SYNC_BYTE, phase == 0 ? SYNC_RESET : 8'($urandom));
      write_reg(REG_ACCEPT_TYPE, phase == 0 ? TYPE_RESET : 8'($urandom));
      send_idle_pct  = (phase == 1) ? 84 : (phase == 3) ? 35 : 0;
      recv_stall_pct = (phase == 2) ? 84 : (phase == 3) ? 35 : 0;
      if (phase == 0) hold_req <= 1'b1;
      random_traffic(PHASE_WORDS);
    end
    req_ch.valid <= 1'b0;

    @(posedge clk);
    wait (pending == 0);
    repeat (50) @(posedge clk);
    if (fail_cnt == 0)
      $display("sync_length_xor_frame_deframer: match");
    else
      $display("sync_length_xor_frame_deframer: mismatch");
    $finish;
  end

endmodule

// File: sync_length_xor_frame_deframer.f
hdl/sldf_pkg.sv
hdl/sldf_stream_if.sv
hdl/sldf_ram.sv
hdl/sync_length_xor_frame_deframer.sv
sim/sldf_scoreboard.sv
sim/sync_length_xor_frame_deframer_tb.sv
